// ===== rtl/core/ltt_pkg.sv =====
// Shared types, constants and helpers for the lambda-theta tree engine.
// Used by the node memory, the combine unit and the top level; no dependencies.
package ltt_pkg;

	localparam int TASKS     = 64;
	localparam int LVLS      = 6;
	localparam int LEAVES    = 1 << LVLS;
	localparam int NODES     = 2 * LEAVES - 1;
	localparam int NODE_AW   = $clog2(NODES);
	localparam int LEAF_BASE = LEAVES - 1;

	localparam int EW = 38;
	localparam int TW = 48;
	localparam int AW = 7;

	localparam logic signed [TW-1:0] NEG_INF  = {1'b1, {(TW-1){1'b0}}};
	localparam logic signed [AW-1:0] ARG_NONE = '1;

	typedef enum logic [1:0] {
		REQ_CLR   = 2'd0,
		REQ_WHITE = 2'd1,
		REQ_GREY  = 2'd2,
		REQ_RESET = 2'd3
	} req_t;

	typedef struct packed {
		logic        [EW-1:0] energy;
		logic signed [TW-1:0] end_min;
		logic        [EW-1:0] grey_energy;
		logic signed [AW-1:0] energy_arg;
		logic signed [TW-1:0] end_min_opt;
		logic signed [AW-1:0] end_min_arg;
	} node_t;

	localparam node_t NODE_ID = '{
		energy:      '0,
		end_min:     NEG_INF,
		grey_energy: '0,
		energy_arg:  ARG_NONE,
		end_min_opt: NEG_INF,
		end_min_arg: ARG_NONE
	};

	// minus infinity absorbs any energy
	function automatic logic signed [TW-1:0] add_inf(logic signed [TW-1:0] a,
			logic [EW-1:0] b);
		logic signed [TW-1:0] s;
		s = a + $signed({{(TW-EW){1'b0}}, b});
		return (a == NEG_INF) ? NEG_INF : s;
	endfunction

endpackage

// ===== rtl/core/ltt_node_mem.sv =====
// Node store of the tree: one write and one read port, registered read data.
// Per-node valid bits make unwritten or cleared nodes read as the identity. Uses ltt_pkg.
module ltt_node_mem import ltt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               clr,
	input  logic               we,
	input  logic [NODE_AW-1:0] waddr,
	input  node_t              wdata,
	input  logic               re,
	input  logic [NODE_AW-1:0] raddr,
	output node_t              rdata
);

	node_t            mem [NODES];
	node_t            rd_raw_q;
	logic             rd_vld_q;
	logic [NODES-1:0] vld_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rd_raw_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (clr)
				vld_q <= '0;
			else if (we)
				vld_q[waddr] <= 1'b1;
			if (re)
				rd_vld_q <= vld_q[raddr];
		end
	end

	assign rdata = rd_vld_q ? rd_raw_q : NODE_ID;

endmodule

// ===== rtl/core/ltt_combine.sv =====
// Lambda-theta combine of a left and a right child into their parent.
// Pure logic, one level per cycle in the top level. Uses ltt_pkg.
module ltt_combine import ltt_pkg::*; (
	input  node_t l,
	input  node_t r,
	output node_t p
);

	logic        [EW-1:0] e_left, e_right;
	logic signed [TW-1:0] t, c1, c2, c3;

	always_comb begin
		t       = add_inf(l.end_min, r.energy);
		e_left  = l.grey_energy + r.energy;
		e_right = l.energy + r.grey_energy;
		c1      = r.end_min_opt;
		c2      = add_inf(l.end_min, r.grey_energy);
		c3      = add_inf(l.end_min_opt, r.energy);

		p.energy  = l.energy + r.energy;
		p.end_min = (r.end_min > t) ? r.end_min : t;

		if (e_left > e_right) begin
			p.grey_energy = e_left;
			p.energy_arg  = l.energy_arg;
		end else begin
			p.grey_energy = e_right;
			p.energy_arg  = r.energy_arg;
		end

		// first candidate that beats or ties both others wins
		if (c1 >= c2 && c1 >= c3) begin
			p.end_min_opt = c1;
			p.end_min_arg = r.end_min_arg;
		end else if (c2 >= c3) begin
			p.end_min_opt = c2;
			p.end_min_arg = r.energy_arg;
		end else begin
			p.end_min_opt = c3;
			p.end_min_arg = l.end_min_arg;
		end
	end

endmodule

// ===== rtl/core/lambda_theta_tree_engine.sv =====
// Top level of the lambda-theta tree engine: request sequencer, path walk, result register.
// Depends on ltt_pkg, ltt_node_mem and ltt_combine.
//
//   channel | dir | handshake           | beat fields
//   in      | in  | in_valid / in_stall | req_type, slot, est, length
//   out     | out | out_valid/out_stall | ect, ect_opt, responsible, total_energy
//
// Insert, mark and slot reset: from accept, a leaf write, then one read-combine-write per tree
// level over 6 levels, then the result load once the output register is free.
// Clear all: all node valid bits drop together at accept, no sweep.
// One request at a time: in_stall is high from accept until the result is loaded.
// Reset leaves the tree at the identity and the channels empty.
// A stalled result holds; the final load waits until the output register frees.
module lambda_theta_tree_engine import ltt_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           req_type,
	input  logic [5:0]           slot,
	input  logic signed [31:0]   est,
	input  logic [30:0]          length,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic signed [TW-1:0] ect,
	output logic signed [TW-1:0] ect_opt,
	output logic signed [AW-1:0] responsible,
	output logic [36:0]          total_energy
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_LEAF = 4'b0010,
		S_LVL  = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t               state_q;
	node_t                cur_q;
	node_t                root_q;
	logic [NODE_AW-1:0]   idx_q;
	logic                 out_valid_q;

	logic                 accept;
	logic                 mem_clr, mem_we, mem_re;
	logic [NODE_AW-1:0]   waddr, raddr, par, pos;
	node_t                wdata, sib_data, comb, l_in, r_in, leaf_val;
	logic signed [TW-1:0] leaf_end;
	logic                 slot_ok;
	logic                 out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign slot_ok   = {1'b0, slot} < NODE_AW'(TASKS);
	assign par       = NODE_AW'((idx_q - NODE_AW'(1)) >> 1);

	// leaf contents for the request
	assign leaf_end = $signed({{(TW-32){est[31]}}, est})
		+ $signed({{(TW-31){1'b0}}, length});

	always_comb begin
		leaf_val = NODE_ID;
		unique case (req_t'(req_type))
			REQ_WHITE: begin
				leaf_val.energy      = {{(EW-31){1'b0}}, length};
				leaf_val.end_min     = leaf_end;
				leaf_val.grey_energy = {{(EW-31){1'b0}}, length};
				leaf_val.end_min_opt = leaf_end;
			end
			REQ_GREY: begin
				leaf_val.grey_energy = {{(EW-31){1'b0}}, length};
				leaf_val.energy_arg  = {1'b0, slot};
				leaf_val.end_min_opt = leaf_end;
				leaf_val.end_min_arg = {1'b0, slot};
			end
			default: leaf_val = NODE_ID;
		endcase
	end

	// odd heap index is a left child
	assign l_in = idx_q[0] ? cur_q : sib_data;
	assign r_in = idx_q[0] ? sib_data : cur_q;

	ltt_combine u_comb (
		.l (l_in),
		.r (r_in),
		.p (comb)
	);

	// write the node just finished, fetch its sibling for the next combine up
	always_comb begin
		pos     = (state_q == S_LEAF) ? idx_q : par;
		waddr   = pos;
		wdata   = (state_q == S_LEAF) ? cur_q : comb;
		raddr   = pos[0] ? NODE_AW'(pos + NODE_AW'(1)) : NODE_AW'(pos - NODE_AW'(1));
		mem_we  = (state_q == S_LEAF) || (state_q == S_LVL);
		mem_re  = (state_q == S_LEAF) || ((state_q == S_LVL) && (par != '0));
		mem_clr = accept && (req_t'(req_type) == REQ_CLR);
	end

	ltt_node_mem u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (mem_clr),
		.we     (mem_we),
		.waddr  (waddr),
		.wdata  (wdata),
		.re     (mem_re),
		.raddr  (raddr),
		.rdata  (sib_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			root_q      <= NODE_ID;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req_t'(req_type) == REQ_CLR) begin
							root_q  <= NODE_ID;
							state_q <= S_DONE;
						end else if (slot_ok)
							state_q <= S_LEAF;
						else
							state_q <= S_DONE;
					end
				end
				S_LEAF: state_q <= S_LVL;
				S_LVL: begin
					if (par == '0) begin
						root_q  <= comb;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// path registers: payload only
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q <= leaf_val;
			idx_q <= NODE_AW'(LEAF_BASE) + NODE_AW'(slot);
		end else if (state_q == S_LVL) begin
			cur_q <= comb;
			idx_q <= par;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			ect          <= root_q.end_min;
			ect_opt      <= root_q.end_min_opt;
			responsible  <= root_q.end_min_arg;
			total_energy <= root_q.energy[36:0];
		end
	end

	assign out_valid = out_valid_q;

	// the walk never combines above the root
	a_lvl_not_root: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LVL |-> idx_q != '0)
		else $error("level step entered at the root");

	a_leaf_index: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LEAF |-> idx_q >= NODE_AW'(LEAF_BASE))
		else $error("leaf write outside the leaf row");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result raised outside the final step");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mem_clr |-> !mem_we)
		else $error("node write during clear");

endmodule

// ===== tb/sv/lambda_theta_tree_engine_checker.sv =====
// Result checker for the lambda-theta tree engine: mirrors the node tree, predicts each root beat.
// Depends on ltt_pkg for node layout, request codes and tree sizes.
module lambda_theta_tree_engine_checker import ltt_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic [1:0]           req_type,
	input  logic [5:0]           slot,
	input  logic signed [31:0]   est,
	input  logic [30:0]          length,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic signed [TW-1:0] ect,
	input  logic signed [TW-1:0] ect_opt,
	input  logic signed [AW-1:0] responsible,
	input  logic [36:0]          total_energy,
	output int                   mismatches,
	output int                   pending
);

	typedef struct packed {
		logic signed [TW-1:0] ect;
		logic signed [TW-1:0] ect_opt;
		logic signed [AW-1:0] responsible;
		logic [36:0]          total_energy;
	} root_beat_t;

	node_t      tree [NODES];
	root_beat_t root_q [$];
	int         err_count;

	// keep minus infinity absorbing
	function automatic logic signed [TW-1:0] absorb_add(logic signed [TW-1:0] t,
			logic [EW-1:0] e);
		if (t == NEG_INF)
			return NEG_INF;
		return t + {{(TW-EW){1'b0}}, e};
	endfunction

	function automatic node_t merge_children(node_t l, node_t r);
		node_t                p;
		logic [EW-1:0]        e_l, e_r;
		logic signed [TW-1:0] r_end, via, c1, c2, c3;
		p.energy = l.energy + r.energy;
		r_end = r.end_min;
		via = absorb_add(l.end_min, r.energy);
		p.end_min = (r_end > via) ? r_end : via;
		e_l = l.grey_energy + r.energy;
		e_r = l.energy + r.grey_energy;
		// tie on grey energy goes right
		if (e_l > e_r) begin
			p.grey_energy = e_l;
			p.energy_arg  = l.energy_arg;
		end else begin
			p.grey_energy = e_r;
			p.energy_arg  = r.energy_arg;
		end
		c1 = r.end_min_opt;
		c2 = absorb_add(l.end_min, r.grey_energy);
		c3 = absorb_add(l.end_min_opt, r.energy);
		if (c1 >= c2 && c1 >= c3) begin
			p.end_min_opt = c1;
			p.end_min_arg = r.end_min_arg;
		end else if (c2 >= c3) begin
			p.end_min_opt = c2;
			p.end_min_arg = r.energy_arg;
		end else begin
			p.end_min_opt = c3;
			p.end_min_arg = l.end_min_arg;
		end
		return p;
	endfunction

	function automatic node_t leaf_for(req_t rq, logic [5:0] sl, logic signed [31:0] st,
			logic [30:0] ln);
		node_t                n;
		logic signed [TW-1:0] fin;
		logic [EW-1:0]        e;
		fin = {{(TW-32){st[31]}}, st} + {{(TW-31){1'b0}}, ln};
		e = {{(EW-31){1'b0}}, ln};
		n = NODE_ID;
		case (rq)
		REQ_WHITE: begin
			n.energy      = e;
			n.end_min     = fin;
			n.grey_energy = e;
			n.end_min_opt = fin;
		end
		REQ_GREY: begin
			n.grey_energy = e;
			n.energy_arg  = {1'b0, sl};
			n.end_min_opt = fin;
			n.end_min_arg = {1'b0, sl};
		end
		default: ;
		endcase
		return n;
	endfunction

	task automatic apply_request(input req_t rq, input logic [5:0] sl,
			input logic signed [31:0] st, input logic [30:0] ln);
		int         i;
		root_beat_t beat;
		if (rq == REQ_CLR) begin
			foreach (tree[k])
				tree[k] = NODE_ID;
		end else if (sl < TASKS) begin
			i = LEAF_BASE + sl;
			tree[i] = leaf_for(rq, sl, st, ln);
			// walk the leaf path up to the root
			while (i > 0) begin
				i = (i - 1) / 2;
				tree[i] = merge_children(tree[2*i+1], tree[2*i+2]);
			end
		end
		beat = '{tree[0].end_min, tree[0].end_min_opt, tree[0].end_min_arg,
			tree[0].energy[36:0]};
		root_q = {root_q, beat};
	endtask

	always @(posedge clk or negedge arst_n) begin
		root_beat_t seen, want;
		if (!arst_n) begin
			foreach (tree[k])
				tree[k] = NODE_ID;
			root_q.delete();
			err_count = 0;
			mismatches <= 0;
			pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				seen = '{ect, ect_opt, responsible, total_energy};
				if (root_q.size() == 0) begin
					err_count++;
					if (err_count <= 10)
						$display("%0t unexpected beat: ect=%0d ect_opt=%0d resp=%0d energy=%0d",
							$time, seen.ect, seen.ect_opt, seen.responsible,
							seen.total_energy);
				end else begin
					want = root_q.pop_front();
					if (seen !== want) begin
						err_count++;
						if (err_count <= 10) begin
							$display("%0t root beat differs", $time);
							$display("  expected ect=%0d ect_opt=%0d resp=%0d energy=%0d",
								want.ect, want.ect_opt, want.responsible,
								want.total_energy);
							$display("  actual   ect=%0d ect_opt=%0d resp=%0d energy=%0d",
								seen.ect, seen.ect_opt, seen.responsible,
								seen.total_energy);
						end
					end
				end
			end
			if (in_valid && !in_stall)
				apply_request(req_t'(req_type), slot, est, length);
			mismatches <= err_count;
			pending <= root_q.size();
		end
	end

endmodule

// ===== tb/sv/lambda_theta_tree_engine_test.sv =====
// Top of the lambda-theta tree engine test: clock, reset, request stimulus and verdict.
// Depends on ltt_pkg, the engine RTL and lambda_theta_tree_engine_checker.
module lambda_theta_tree_engine_test;
	import ltt_pkg::*;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	logic [1:0]           req_type  = REQ_CLR;
	logic [5:0]           slot      = '0;
	logic signed [31:0]   est       = '0;
	logic [30:0]          length    = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic signed [TW-1:0] ect;
	logic signed [TW-1:0] ect_opt;
	logic signed [AW-1:0] responsible;
	logic [36:0]          total_energy;
	int                   mismatches;
	int                   pending;
	int                   idle_pct  = 0;
	int                   stall_pct = 0;

	int phase_idle  [4] = '{0, 87, 0, 13};
	int phase_stall [4] = '{0, 0, 87, 13};

	always #5 clk = ~clk;

	always @(posedge clk)
		out_stall <= ($urandom_range(99) < stall_pct);

	lambda_theta_tree_engine i_dut (.*);

	lambda_theta_tree_engine_checker i_checker (.*);

	function automatic logic signed [31:0] pick_start();
		case ($urandom_range(9))
		0:       return 32'sh8000_0000;
		1:       return 32'sh7FFF_FFFF;
		2, 3:    return $urandom;
		default: return $signed($urandom_range(2000)) - 32'sd1000;
		endcase
	endfunction

	function automatic logic [30:0] pick_length();
		case ($urandom_range(9))
		0:       return '0;
		1:       return 31'h7FFF_FFFF;
		2, 3:    return 31'($urandom);
		default: return 31'($urandom_range(600));
		endcase
	endfunction

	// bias toward a few low slots so leaves get overwritten often
	function automatic logic [5:0] pick_slot();
		if ($urandom_range(3) == 0)
			return 6'($urandom_range(7));
		return 6'($urandom_range(63));
	endfunction

	task automatic send_req(input req_t rq, input logic [5:0] sl,
			input logic signed [31:0] st, input logic [30:0] ln);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		req_type  <= rq;
		slot      <= sl;
		est       <= st;
		length    <= ln;
		in_valid  <= 1'b1;
		// hold the beat until it is taken
		do
			@(posedge clk);
		while (in_stall);
	endtask

	task automatic random_request();
		int   roll;
		req_t rq;
		roll = $urandom_range(99);
		if (roll < 5)
			rq = REQ_CLR;
		else if (roll < 50)
			rq = REQ_WHITE;
		else if (roll < 80)
			rq = REQ_GREY;
		else
			rq = REQ_RESET;
		send_req(rq, pick_slot(), pick_start(), pick_length());
	endtask

	initial begin
		#3_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_req(REQ_CLR, '1, '1, '1);
		send_req(REQ_WHITE, 6'd0, 32'sh8000_0000, 31'd0);
		send_req(REQ_WHITE, 6'd63, 32'sh7FFF_FFFF, 31'h7FFF_FFFF);
		send_req(REQ_GREY, 6'd32, 32'sd0, 31'h7FFF_FFFF);
		send_req(REQ_GREY, 6'd1, 32'sh8000_0000, 31'd0);
		send_req(REQ_RESET, 6'd63, 32'sd0, 31'd0);
		send_req(REQ_RESET, 6'd5, '1, '1);
		// equal white tasks, then equal grey tasks: ties in the grey energy and candidate compares
		send_req(REQ_WHITE, 6'd10, 32'sd100, 31'd50);
		send_req(REQ_WHITE, 6'd11, 32'sd100, 31'd50);
		send_req(REQ_GREY, 6'd20, 32'sd0, 31'd40);
		send_req(REQ_GREY, 6'd21, 32'sd0, 31'd40);
		send_req(REQ_GREY, 6'd12, 32'sd0, 31'd0);
		send_req(REQ_WHITE, 6'd40, -32'sd1, 31'h7FFF_FFFF);
		send_req(REQ_GREY, 6'd40, -32'sd1, 31'h7FFF_FFFF);
		send_req(REQ_RESET, 6'd32, 32'sd0, 31'd0);
		send_req(REQ_CLR, 6'd0, 32'sd0, 31'd0);
		// grey only: theta side stays at minus infinity
		send_req(REQ_GREY, 6'd0, 32'sh7FFF_FFFF, 31'h7FFF_FFFF);
		send_req(REQ_WHITE, 6'd63, 32'sh8000_0000, 31'd0);
		send_req(REQ_CLR, 6'd63, 32'sh7FFF_FFFF, 31'h7FFF_FFFF);

		for (int p = 0; p < 4; p++) begin
			idle_pct  = phase_idle[p];
			stall_pct = phase_stall[p];
			if (p == 3) begin
				// fill every slot at full length for peak energy
				for (int s = 0; s < TASKS; s++)
					send_req(REQ_WHITE, 6'(s), pick_start(), 31'h7FFF_FFFF);
				repeat (36)
					random_request();
			end else begin
				repeat (100)
					random_request();
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/ltt_pkg.sv
rtl/core/ltt_node_mem.sv
rtl/core/ltt_combine.sv
rtl/core/lambda_theta_tree_engine.sv
tb/sv/lambda_theta_tree_engine_checker.sv
tb/sv/lambda_theta_tree_engine_test.sv
